// ===== hw/rtl/gn3t_pkg.sv =====
package gn3t_pkg;

  localparam int LUT_DEPTH       = 256;
  localparam int MAX_OCTAVES     = 8;
  localparam int COORD_FRAC_BITS = 16;

  localparam int TBL_W = $clog2(LUT_DEPTH);
  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  // noise values stay within about +-229376
  localparam int VAL_W = 20;
  localparam int ACC_W = VAL_W + MAX_OCTAVES + 5;

  localparam logic [1:0] CMD_EVAL = 2'd0;
  localparam logic [1:0] CMD_PERM = 2'd1;
  localparam logic [1:0] CMD_GRAD = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  typedef logic [TBL_W-1:0] cell_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic             live;
    logic [OCT_W-1:0] oct;
  } pass_tag_t;

  typedef struct packed {
    logic        perm_we;
    logic        grad_we;
    cell_t       idx;
    logic [7:0]  perm;
    logic [47:0] grad;
  } tbl_wr_t;

endpackage

// ===== hw/rtl/gradient_noise_3d_turbulence.sv =====
// 3D gradient noise with octave turbulence.
// Request channel (req_valid / req_stall) carries one word per command:
// cmd 0 evaluates a Q16.16 point, cmd 1 loads a permutation entry, cmd 2
// loads a gradient entry, cmd 3 is dropped. Only cmd 0 returns a word on
// the result channel (res_valid / res_stall): noise_value and turbulence.
// The user is to write octave_count through cfg_we / cfg_wdata while idle;
// the block itself does not enforce this. Each point is run through the
// noise pipeline once per octave, max(octave_count, 1) passes capped at 8,
// one pass per cycle while the result is not stalled; a point holds the
// request side until its last pass. The pipe is 13 stages plus the output
// register.
// The pass rate is set by the single shared eight-corner pipeline.
// Load commands wait until all points in flight have drained.
// A stalled result freezes the whole pipe; nothing is lost or repeated.
// Reset clears the pipe and sets octave_count to 4; the tables are not
// cleared and must be loaded before the first evaluation.
module gradient_noise_3d_turbulence import gn3t_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] point_z,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  perm_value,
  input  logic [15:0] grad_x,
  input  logic [15:0] grad_y,
  input  logic [15:0] grad_z,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [17:0] noise_value,
  output logic [17:0] turbulence
);

  logic                    en;
  logic                    pipe_busy;
  tbl_wr_t                 wr;
  logic                    pass_valid;
  pass_tag_t               pass_tag;
  logic [31:0]             px, py, pz;
  logic                    val_valid;
  pass_tag_t               val_tag;
  logic signed [VAL_W-1:0] value;

  assign en = !(res_valid && res_stall);

  gn3t_issue u_issue (
    .clk(clk), .rst(rst), .en(en), .pipe_busy(pipe_busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .cmd(cmd),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .entry_index(entry_index), .perm_value(perm_value),
    .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
    .req_stall(req_stall), .wr(wr),
    .pass_valid(pass_valid), .pass_tag(pass_tag), .px(px), .py(py), .pz(pz)
  );

  gn3t_core u_core (
    .clk(clk), .rst(rst), .en(en), .wr(wr),
    .pass_valid(pass_valid), .pass_tag(pass_tag), .px(px), .py(py), .pz(pz),
    .busy(pipe_busy), .val_valid(val_valid), .val_tag(val_tag), .value(value)
  );

  gn3t_accum u_accum (
    .clk(clk), .rst(rst), .en(en),
    .val_valid(val_valid), .val_tag(val_tag), .value(value),
    .res_valid(res_valid), .noise_value(noise_value), .turbulence(turbulence)
  );

endmodule

// ===== hw/rtl/gn3t_ram.sv =====
module gn3t_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hw/rtl/gn3t_issue.sv =====
module gn3t_issue import gn3t_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        pipe_busy,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        req_valid,
  input  logic [1:0]  cmd,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] point_z,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  perm_value,
  input  logic [15:0] grad_x,
  input  logic [15:0] grad_y,
  input  logic [15:0] grad_z,
  output logic        req_stall,
  output tbl_wr_t     wr,
  output logic        pass_valid,
  output pass_tag_t   pass_tag,
  output logic [31:0] px,
  output logic [31:0] py,
  output logic [31:0] pz
);

  logic [3:0]       octave_count;
  logic             busy;
  logic [OCT_W-1:0] oct;
  logic [OCT_W-1:0] last_oct;
  logic             live;
  logic [31:0]      bx, by, bz;
  logic             is_last;
  logic             is_load;
  logic             accept;
  logic [4:0]       n_oct;

  assign is_last = (oct == last_oct);
  assign is_load = (cmd == CMD_PERM) || (cmd == CMD_GRAD);
  // loads wait for the pipe to drain so earlier points see the old tables
  assign req_stall = !en || (busy && !is_last) || (is_load && (busy || pipe_busy));
  assign accept    = req_valid && !req_stall;

  assign n_oct = ({1'b0, octave_count} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
                                                          : {1'b0, octave_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd4;
      busy         <= 1'b0;
    end else begin
      if (cfg_we) begin
        octave_count <= cfg_wdata;
      end
      if (accept && cmd == CMD_EVAL) begin
        busy <= 1'b1;
      end else if (en && busy && is_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_EVAL) begin
      oct      <= '0;
      last_oct <= (n_oct == 5'd0) ? '0 : OCT_W'(n_oct - 5'd1);
      live     <= (n_oct != 5'd0);
      bx       <= point_x;
      by       <= point_y;
      bz       <= point_z;
    end else if (en && busy && !is_last) begin
      oct <= oct + 1'b1;
    end
  end

  assign wr.perm_we = accept && (cmd == CMD_PERM);
  assign wr.grad_we = accept && (cmd == CMD_GRAD);
  assign wr.idx     = TBL_W'(entry_index);
  assign wr.perm    = perm_value;
  assign wr.grad    = {grad_x, grad_y, grad_z};

  assign pass_valid     = busy;
  assign pass_tag.first = (oct == '0);
  assign pass_tag.last  = is_last;
  assign pass_tag.live  = live;
  assign pass_tag.oct   = oct;
  assign px = bx << oct;
  assign py = by << oct;
  assign pz = bz << oct;

endmodule

// ===== hw/rtl/gn3t_core.sv =====
module gn3t_core import gn3t_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  tbl_wr_t                 wr,
  input  logic                    pass_valid,
  input  pass_tag_t               pass_tag,
  input  logic [31:0]             px,
  input  logic [31:0]             py,
  input  logic [31:0]             pz,
  output logic                    busy,
  output logic                    val_valid,
  output pass_tag_t               val_tag,
  output logic signed [VAL_W-1:0] value
);

  localparam int SH_R = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
  localparam int SH_L = (COORD_FRAC_BITS >= 16) ? 0 : 16 - COORD_FRAC_BITS;
  localparam logic [31:0] FRAC_MASK = 32'((64'd1 << COORD_FRAC_BITS) - 64'd1);
  localparam int NS = 13;

  logic [NS:1] v;
  pass_tag_t   tg [NS:1];

  logic [31:0] pt [3];
  cell_t       c_in [3];
  logic [15:0] t_in [3];

  cell_t       s1_c [3][2];
  logic [15:0] tp [1:5][3];
  logic [15:0] tt2 [3];
  logic [16:0] sp [3:12][3];
  cell_t       s2_cy [2];
  cell_t       s2_cz [2];
  cell_t       s3_cz [2];

  logic [7:0]  pa [2];
  logic [7:0]  pb [4];
  logic [7:0]  pc [8];
  logic [47:0] gd [8];
  cell_t       ab [4];
  cell_t       ac [8];
  cell_t       ga [8];

  logic signed [32:0]      prod [8][3];
  logic signed [VAL_W-1:0] d [8];
  logic signed [38:0]      mx [4];
  logic signed [VAL_W-1:0] lox [4];
  logic signed [VAL_W-1:0] lx [4];
  logic signed [38:0]      my [2];
  logic signed [VAL_W-1:0] loy [2];
  logic signed [VAL_W-1:0] ly [2];
  logic signed [38:0]      mz;
  logic signed [VAL_W-1:0] loz;

  assign pt[0] = px;
  assign pt[1] = py;
  assign pt[2] = pz;

  always_comb begin
    logic signed [31:0] sh;
    logic [31:0]        fr;
    for (int a = 0; a < 3; a++) begin
      sh      = $signed(pt[a]) >>> COORD_FRAC_BITS;
      fr      = pt[a] & FRAC_MASK;
      c_in[a] = sh[TBL_W-1:0];
      t_in[a] = 16'((fr >> SH_R) << SH_L);
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        ab[i*2+j] = TBL_W'(pa[i]) + s2_cy[j];
      end
    end
    for (int ij = 0; ij < 4; ij++) begin
      for (int k = 0; k < 2; k++) begin
        ac[ij*2+k] = TBL_W'(pb[ij]) + s3_cz[k];
      end
    end
    for (int n = 0; n < 8; n++) begin
      ga[n] = TBL_W'(pc[n]);
    end
  end

  gn3t_ram #(.WIDTH(8), .DEPTH(LUT_DEPTH)) u_perm_a (
    .clk(clk), .we(wr.perm_we), .waddr(wr.idx), .wdata(wr.perm), .en(en),
    .raddr_a(s1_c[0][0]), .raddr_b(s1_c[0][1]), .rdata_a(pa[0]), .rdata_b(pa[1])
  );

  for (genvar q = 0; q < 2; q++) begin : g_perm_b
    gn3t_ram #(.WIDTH(8), .DEPTH(LUT_DEPTH)) u_ram (
      .clk(clk), .we(wr.perm_we), .waddr(wr.idx), .wdata(wr.perm), .en(en),
      .raddr_a(ab[2*q]), .raddr_b(ab[2*q+1]), .rdata_a(pb[2*q]), .rdata_b(pb[2*q+1])
    );
  end

  for (genvar q = 0; q < 4; q++) begin : g_perm_c
    gn3t_ram #(.WIDTH(8), .DEPTH(LUT_DEPTH)) u_ram (
      .clk(clk), .we(wr.perm_we), .waddr(wr.idx), .wdata(wr.perm), .en(en),
      .raddr_a(ac[2*q]), .raddr_b(ac[2*q+1]), .rdata_a(pc[2*q]), .rdata_b(pc[2*q+1])
    );
  end

  for (genvar q = 0; q < 4; q++) begin : g_grad
    gn3t_ram #(.WIDTH(48), .DEPTH(LUT_DEPTH)) u_ram (
      .clk(clk), .we(wr.grad_we), .waddr(wr.idx), .wdata(wr.grad), .en(en),
      .raddr_a(ga[2*q]), .raddr_b(ga[2*q+1]), .rdata_a(gd[2*q]), .rdata_b(gd[2*q+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-1:1], pass_valid};
    end
  end

  always_ff @(posedge clk) begin
    logic [17:0]        fac;
    logic [33:0]        sq;
    logic signed [16:0] off [3];
    logic signed [34:0] dsum;
    logic signed [20:0] df;
    if (en) begin
      tg[1] <= pass_tag;
      for (int k = 2; k <= NS; k++) begin
        tg[k] <= tg[k-1];
      end

      // stage 1: lattice split
      for (int a = 0; a < 3; a++) begin
        s1_c[a][0] <= c_in[a];
        s1_c[a][1] <= c_in[a] + 1'b1;
        tp[1][a]   <= t_in[a];
      end
      for (int k = 2; k <= 5; k++) begin
        tp[k] <= tp[k-1];
      end

      // stage 2: first smoothstep product, y/z cells follow the x lookup
      for (int a = 0; a < 3; a++) begin
        tt2[a] <= 16'((32'(tp[1][a]) * 32'(tp[1][a])) >> 16);
      end
      s2_cy <= s1_c[1];
      s2_cz <= s1_c[2];
      s3_cz <= s2_cz;

      // stage 3: smoothstep finish
      for (int a = 0; a < 3; a++) begin
        fac       = 18'd196608 - {1'b0, tp[2][a], 1'b0};
        sq        = 34'(tt2[a]) * 34'(fac);
        sp[3][a] <= sq[32:16];
      end
      for (int k = 4; k <= 12; k++) begin
        sp[k] <= sp[k-1];
      end

      // stage 5 -> 6: gradient times offset
      for (int n = 0; n < 8; n++) begin
        off[0] = n[2] ? $signed({1'b1, tp[5][0]}) : $signed({1'b0, tp[5][0]});
        off[1] = n[1] ? $signed({1'b1, tp[5][1]}) : $signed({1'b0, tp[5][1]});
        off[2] = n[0] ? $signed({1'b1, tp[5][2]}) : $signed({1'b0, tp[5][2]});
        prod[n][0] <= $signed(gd[n][47:32]) * off[0];
        prod[n][1] <= $signed(gd[n][31:16]) * off[1];
        prod[n][2] <= $signed(gd[n][15:0]) * off[2];
      end

      // stage 6 -> 7: dot with floor
      for (int n = 0; n < 8; n++) begin
        dsum = 35'(prod[n][0]) + 35'(prod[n][1]) + 35'(prod[n][2]);
        d[n] <= dsum[34:15];
      end

      // x blend: corner index is x*4 + y*2 + z
      for (int jk = 0; jk < 4; jk++) begin
        df       = 21'(d[4+jk]) - 21'(d[jk]);
        mx[jk]  <= df * $signed({1'b0, sp[7][0]});
        lox[jk] <= d[jk];
      end
      for (int jk = 0; jk < 4; jk++) begin
        lx[jk] <= lox[jk] + VAL_W'(mx[jk] >>> 16);
      end

      // y blend
      for (int k = 0; k < 2; k++) begin
        df      = 21'(lx[2+k]) - 21'(lx[k]);
        my[k]  <= df * $signed({1'b0, sp[9][1]});
        loy[k] <= lx[k];
      end
      for (int k = 0; k < 2; k++) begin
        ly[k] <= loy[k] + VAL_W'(my[k] >>> 16);
      end

      // z blend, then add one half
      df    = 21'(ly[1]) - 21'(ly[0]);
      mz   <= df * $signed({1'b0, sp[11][2]});
      loz  <= ly[0];
      value <= loz + VAL_W'(mz >>> 16) + VAL_W'(32768);
    end
  end

  assign busy      = |v;
  assign val_valid = v[NS];
  assign val_tag   = tg[NS];

endmodule

// ===== hw/rtl/gn3t_accum.sv =====
module gn3t_accum import gn3t_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    val_valid,
  input  pass_tag_t               val_tag,
  input  logic signed [VAL_W-1:0] value,
  output logic                    res_valid,
  output logic [17:0]             noise_value,
  output logic [17:0]             turbulence
);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sum;
  logic [ACC_W-1:0]        mag;
  logic [ACC_W-1:0]        mag_sh;
  logic [17:0]             nv_sat;
  logic [17:0]             nv_hold;
  logic [OCT_W:0]          wsh;

  assign wsh = (OCT_W+1)'(MAX_OCTAVES) - {1'b0, val_tag.oct};

  always_comb begin
    logic signed [ACC_W-1:0] contrib;
    contrib = val_tag.live ? (ACC_W'(value) <<< wsh) : '0;
    sum     = (val_tag.first ? '0 : acc) + contrib;
    mag     = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
    mag_sh  = mag >> MAX_OCTAVES;
  end

  always_comb begin
    if (value > VAL_W'(131071)) begin
      nv_sat = 18'h1FFFF;
    end else if (value < -VAL_W'(131072)) begin
      nv_sat = 18'h20000;
    end else begin
      nv_sat = value[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= val_valid && val_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en && val_valid) begin
      acc <= sum;
      if (val_tag.first) begin
        nv_hold <= nv_sat;
      end
      if (val_tag.last) begin
        noise_value <= val_tag.first ? nv_sat : nv_hold;
        turbulence  <= (mag_sh > ACC_W'(262143)) ? 18'h3FFFF : mag_sh[17:0];
      end
    end
  end

endmodule
